### design/rde_pkg.sv
// Package for the radix digit emitter: field widths, register indexes,
// reset values, the divider status struct and the digit-to-character lookup.
// No dependencies.
package rde_pkg;

  localparam int VALUE_W    = 63;
  localparam int CHAR_W     = 8;
  localparam int BASE_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int DVAL_W     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_BASE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH = 2'd2;

  localparam logic [BASE_W-1:0]     BASE_RESET       = 5'd10;
  localparam logic [CFG_DATA_W-1:0] CHARS_LOW_RESET  = 64'h3736353433323130;
  localparam logic [CFG_DATA_W-1:0] CHARS_HIGH_RESET = 64'h6665646362613938;

  typedef struct packed {
    logic done;
    logic nonzero;
  } div_status_t;

  // Byte d[2:0] of the low word for digits 0..7, of the high word otherwise.
  function automatic logic [CHAR_W-1:0] char_of(
    input logic [DVAL_W-1:0]     d,
    input logic [CFG_DATA_W-1:0] low,
    input logic [CFG_DATA_W-1:0] high
  );
    logic [CFG_DATA_W-1:0] word;
    word = d[3] ? high : low;
    return word[{d[2:0], 3'b000} +: CHAR_W];
  endfunction

endpackage

### design/rde_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rde_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/rde_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Depends on rde_pkg for the value width and the status struct.
module rde_divider #(
  parameter int MAX_BASE = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           load,
  input  logic [rde_pkg::VALUE_W-1:0]    dividend,
  input  logic [$clog2(MAX_BASE+1)-1:0]  divisor,
  output logic [$clog2(MAX_BASE+1)-1:0]  remainder,
  output rde_pkg::div_status_t           status
);

  localparam int DivW = $clog2(MAX_BASE + 1);
  localparam int CntW = $clog2(rde_pkg::VALUE_W);
  localparam logic [CntW-1:0] LastStep = CntW'(rde_pkg::VALUE_W - 1);

  logic [rde_pkg::VALUE_W-1:0] quo;
  logic [DivW-1:0]             rem;
  logic [CntW-1:0]             cnt;
  logic                        busy;
  logic                        done;
  logic                        nonzero;

  logic [DivW:0]   trial;
  logic            qbit;
  logic [DivW-1:0] rem_next;

  // The quotient register shifts out the dividend while the quotient bits
  // shift in, so a new division can start from the previous quotient.
  always_comb begin
    trial    = {rem, quo[rde_pkg::VALUE_W-1]};
    qbit     = (trial >= {1'b0, divisor});
    rem_next = qbit ? DivW'(trial - {1'b0, divisor}) : DivW'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == LastStep);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == LastStep)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt     <= '0;
      rem     <= '0;
      nonzero <= 1'b0;
      if (load) begin
        quo <= dividend;
      end
    end else if (busy) begin
      cnt     <= cnt + 1'b1;
      rem     <= rem_next;
      quo     <= {quo[rde_pkg::VALUE_W-2:0], qbit};
      nonzero <= nonzero | qbit;
    end
  end

  assign remainder      = rem;
  assign status.done    = done;
  assign status.nonzero = nonzero;

endmodule

### design/radix_digit_emitter_unit.sv
// Top level of the radix digit emitter: config registers, digit sequencer,
// digit stack and output register. Depends on rde_pkg, rde_divider, rde_ram.
//
//   channel | signals                          | carries
//   in      | in_valid, in_ready, value        | one number per beat
//   out     | out_valid, out_ready, digit_char, last | one character per beat
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | one register write
//
// Each digit is one pass of the bit-serial divider, and each character is read
// back from the digit stack in a read state, then put into the output register
// in a load state.
// Synchronous reset restores the register reset values and idles the block.
// A stalled output holds the sequencer before the next stack read; a new
// number is taken once the previous one's last character is in the output
// register.
module radix_digit_emitter_unit #(
  parameter int MAX_DIGITS = 64,
  parameter int MAX_BASE   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rde_pkg::VALUE_W-1:0]       value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rde_pkg::CHAR_W-1:0]        digit_char,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rde_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rde_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int DivW   = $clog2(MAX_BASE + 1);
  localparam int DigitW = $clog2(MAX_BASE);
  localparam int AddrW  = $clog2(MAX_DIGITS);
  localparam int CntW   = $clog2(MAX_DIGITS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_LOAD = 2'd3;

  logic [rde_pkg::BASE_W-1:0]     base;
  logic [rde_pkg::CFG_DATA_W-1:0] chars_low;
  logic [rde_pkg::CFG_DATA_W-1:0] chars_high;
  logic [DivW-1:0]                eff_base;

  logic [1:0]       state;
  logic [CntW-1:0]  n;
  logic [CntW-1:0]  n_next;
  logic [AddrW-1:0] rd_ptr;
  logic             more;

  logic                        div_start;
  logic                        div_load;
  logic [DivW-1:0]             remainder;
  rde_pkg::div_status_t        div_status;
  logic [DigitW-1:0]           rd_digit;
  logic                        stack_we;

  // Configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base       <= rde_pkg::BASE_RESET;
      chars_low  <= rde_pkg::CHARS_LOW_RESET;
      chars_high <= rde_pkg::CHARS_HIGH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        rde_pkg::REG_BASE:       base       <= cfg_data[rde_pkg::BASE_W-1:0];
        rde_pkg::REG_CHARS_LOW:  chars_low  <= cfg_data;
        rde_pkg::REG_CHARS_HIGH: chars_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (base < 5'd2) begin
      eff_base = DivW'(2);
    end else if (base > 5'(MAX_BASE)) begin
      eff_base = DivW'(MAX_BASE);
    end else begin
      eff_base = DivW'(base);
    end
  end

  // Sequencer
  assign in_ready  = (state == S_IDLE);
  assign n_next    = n + 1'b1;
  assign more      = div_status.nonzero && (n_next != CntW'(MAX_DIGITS));
  assign stack_we  = (state == S_DIV) && div_status.done;
  assign div_load  = (state == S_IDLE);
  assign div_start = (in_valid && in_ready) || (stack_we && more);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DIV;
            n     <= '0;
          end
        end
        S_DIV: begin
          if (div_status.done) begin
            n <= n_next;
            if (!more) begin
              rd_ptr <= n[AddrW-1:0];
              state  <= S_READ;
            end
          end
        end
        S_READ: begin
          if (!out_valid || out_ready) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (rd_ptr == '0) begin
            state <= S_IDLE;
          end else begin
            rd_ptr <= rd_ptr - 1'b1;
            state  <= S_READ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  rde_divider #(
    .MAX_BASE (MAX_BASE)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .load      (div_load),
    .dividend  (value),
    .divisor   (eff_base),
    .remainder (remainder),
    .status    (div_status)
  );

  // Digits are pushed least significant first and read back in reverse.
  rde_ram #(
    .WIDTH (DigitW),
    .DEPTH (MAX_DIGITS)
  ) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (n[AddrW-1:0]),
    .wdata (remainder[DigitW-1:0]),
    .raddr (rd_ptr),
    .rdata (rd_digit)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_LOAD) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      digit_char <= rde_pkg::char_of(rde_pkg::DVAL_W'(rd_digit), chars_low, chars_high);
      last       <= (rd_ptr == '0);
    end
  end

  // Checks
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_we |-> (n < CntW'(MAX_DIGITS)))
    else $error("digit stack written past its depth");

  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> !out_valid)
    else $error("output register loaded while still holding a beat");

  a_last_beat: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) && (rd_ptr == '0) |=> out_valid && last && (state == S_IDLE))
    else $error("final digit not marked last");

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && !div_status.done |-> !div_start)
    else $error("divider restarted mid-division");

endmodule

### test/tb_radix_digit_emitter_unit.sv
`timescale 1ns / 1ps
// Testbench for radix_digit_emitter_unit: a directed table followed by random
// phases, with every digit checked against typed expectations or a digit predictor in this file.
// Depends on rde_pkg and the radix_digit_emitter_unit RTL.
module tb_radix_digit_emitter_unit;

  localparam logic [rde_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int TYPED_W = 160;

  typedef struct packed {
    logic [rde_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } digit_entry_t;

  typedef struct {
    logic                           is_reg;
    logic [rde_pkg::CFG_IDX_W-1:0]  idx;
    logic [rde_pkg::CFG_DATA_W-1:0] data;
    logic [rde_pkg::VALUE_W-1:0]    number;
    int                             n_typed;
    logic [TYPED_W-1:0]             typed;
  } stim_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [rde_pkg::VALUE_W-1:0]    value = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [rde_pkg::CHAR_W-1:0]     digit_char;
  logic                           last;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [rde_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rde_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the configuration registers.
  logic [rde_pkg::BASE_W-1:0]     shadow_base = rde_pkg::BASE_RESET;
  logic [rde_pkg::CFG_DATA_W-1:0] shadow_low  = rde_pkg::CHARS_LOW_RESET;
  logic [rde_pkg::CFG_DATA_W-1:0] shadow_high = rde_pkg::CHARS_HIGH_RESET;

  digit_entry_t expected_digits[$];
  digit_entry_t got_digit;
  stim_row_t    stim_rows[$];
  int           err_count = 0;
  logic         idle_on = 1'b1;

  radix_digit_emitter_unit uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Output side: check each accepted beat, then pick the next ready level.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_digits.size() == 0) begin
        if (err_count < 10)
          $display("unexpected digit beat: char=%h last=%b", digit_char, last);
        err_count++;
      end else begin
        got_digit = expected_digits.pop_front();
        if (digit_char !== got_digit.ch || last !== got_digit.last) begin
          if (err_count < 10)
            $display("digit mismatch: expected char=%h last=%b, got char=%h last=%b",
                     got_digit.ch, got_digit.last, digit_char, last);
          err_count++;
        end
      end
    end
    out_ready <= !idle_on || ($urandom_range(99) >= 31);
  end

  // Expected characters of one number under the shadow configuration.
  task automatic predict_digits(input logic [rde_pkg::VALUE_W-1:0] num);
    logic [rde_pkg::DVAL_W-1:0]     digs[64];
    logic [rde_pkg::VALUE_W-1:0]    rest;
    logic [rde_pkg::VALUE_W-1:0]    radix;
    logic [rde_pkg::CFG_DATA_W-1:0] word;
    digit_entry_t                   entry;
    int                             n;
    rest = num;
    n = 0;
    if (shadow_base < 5'd2)
      radix = rde_pkg::VALUE_W'(2);
    else if (shadow_base > 5'd16)
      radix = rde_pkg::VALUE_W'(16);
    else
      radix = rde_pkg::VALUE_W'(shadow_base);
    do begin
      digs[n] = rde_pkg::DVAL_W'(rest % radix);
      rest = rest / radix;
      n++;
    end while (rest != 0 && n < 64);
    for (int k = 0; k < n; k++) begin
      word = digs[n-1-k][3] ? shadow_high : shadow_low;
      entry.ch = word[8*digs[n-1-k][2:0] +: 8];
      entry.last = (k == n - 1);
      expected_digits.push_back(entry);
    end
  endtask

  task automatic write_reg(input logic [rde_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rde_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rde_pkg::REG_BASE:       shadow_base = data[rde_pkg::BASE_W-1:0];
      rde_pkg::REG_CHARS_LOW:  shadow_low = data;
      rde_pkg::REG_CHARS_HIGH: shadow_high = data;
      default: ;
    endcase
  endtask

  // Sends one number; typed expectations replace the predictor when given.
  task automatic send_number(input logic [rde_pkg::VALUE_W-1:0] num, input int n_typed,
                             input logic [TYPED_W-1:0] typed);
    digit_entry_t entry;
    cfg_valid <= 1'b0;
    if (idle_on) begin
      while ($urandom_range(99) < 31) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    value <= num;
    do @(posedge clk); while (!in_ready);
    if (n_typed > 0) begin
      for (int k = 0; k < n_typed; k++) begin
        entry.ch = typed[8*(n_typed-1-k) +: 8];
        entry.last = (k == n_typed - 1);
        expected_digits.push_back(entry);
      end
    end else begin
      predict_digits(num);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
  endtask

  task automatic add_item(input logic [rde_pkg::VALUE_W-1:0] num, input int n_typed,
                          input logic [TYPED_W-1:0] typed);
    stim_row_t row;
    row.is_reg = 1'b0;
    row.idx = '0;
    row.data = '0;
    row.number = num;
    row.n_typed = n_typed;
    row.typed = typed;
    stim_rows.push_back(row);
  endtask

  task automatic add_reg(input logic [rde_pkg::CFG_IDX_W-1:0] idx,
                         input logic [rde_pkg::CFG_DATA_W-1:0] data);
    stim_row_t row;
    row.is_reg = 1'b1;
    row.idx = idx;
    row.data = data;
    row.number = '0;
    row.n_typed = 0;
    row.typed = '0;
    stim_rows.push_back(row);
  endtask

  function automatic logic [rde_pkg::VALUE_W-1:0] random_number();
    logic [63:0] raw;
    int          sel;
    int          nbits;
    raw = {$urandom, $urandom};
    sel = $urandom_range(99);
    if (sel < 5)
      return '0;
    if (sel < 10)
      return {rde_pkg::VALUE_W{1'b1}};
    if (sel < 70)
      nbits = $urandom_range(12, 1);
    else if (sel < 90)
      nbits = $urandom_range(40, 13);
    else
      nbits = $urandom_range(63, 41);
    return raw[rde_pkg::VALUE_W-1:0] &
           ({rde_pkg::VALUE_W{1'b1}} >> (rde_pkg::VALUE_W - nbits));
  endfunction

  initial begin
    logic [rde_pkg::CFG_DATA_W-1:0] base_word;

    // Reset configuration, base ten.
    add_item(63'd0, 1, "0");
    add_item(63'd9, 1, "9");
    add_item(63'd10, 2, "10");
    add_item({rde_pkg::VALUE_W{1'b1}}, 19, "9223372036854775807");
    // Base sixteen and base two extremes.
    add_reg(rde_pkg::REG_BASE, 64'd16);
    add_item(63'hff, 2, "ff");
    add_item({rde_pkg::VALUE_W{1'b1}}, 16, "7fffffffffffffff");
    add_reg(rde_pkg::REG_BASE, 64'd2);
    add_item(63'd5, 3, "101");
    add_item({rde_pkg::VALUE_W{1'b1}}, 0, '0);
    // A base below two acts as two, one above sixteen acts as sixteen.
    add_reg(rde_pkg::REG_BASE, 64'd0);
    add_item(63'd6, 3, "110");
    add_reg(rde_pkg::REG_BASE, 64'd1);
    add_item(63'd1, 1, "1");
    add_reg(rde_pkg::REG_BASE, 64'd17);
    add_item(63'd255, 2, "ff");
    add_reg(rde_pkg::REG_BASE, {rde_pkg::CFG_DATA_W{1'b1}});
    add_item(63'h1234, 4, "1234");
    // Only the low five bits of the data reach the base register.
    add_reg(rde_pkg::REG_BASE, 64'habcd_0000_0000_0010);
    add_reg(rde_pkg::REG_CHARS_LOW, 64'h0);
    add_reg(rde_pkg::REG_CHARS_HIGH, {rde_pkg::CFG_DATA_W{1'b1}});
    add_item(63'hf80, 0, '0);
    add_item(63'h0, 0, '0);
    add_item(63'h7a5c_3e19, 0, '0);
    // A write to the unused index must leave every register alone.
    add_reg(REG_UNUSED, 64'h5a5a_a5a5_0f0f_f0f0);
    add_item(63'h7, 0, '0);
    add_item(63'h1e, 0, '0);
    add_reg(rde_pkg::REG_BASE, 64'd3);
    add_reg(rde_pkg::REG_CHARS_LOW, 64'h4847_4645_4443_4241);
    add_item(63'h0, 0, '0);
    add_item(63'd1000, 0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_reg) begin
        wait_drained();
        write_reg(stim_rows[i].idx, stim_rows[i].data);
      end else begin
        send_number(stim_rows[i].number, stim_rows[i].n_typed, stim_rows[i].typed);
      end
    end

    // Random phases: each one drains the block before it is reconfigured.
    for (int ph = 0; ph < 7; ph++) begin
      wait_drained();
      base_word = {$urandom, $urandom};
      if (ph == 0)
        base_word[rde_pkg::BASE_W-1:0] = 5'd16;
      else if (ph == 1)
        base_word[rde_pkg::BASE_W-1:0] = 5'd2;
      else if (ph == 2)
        base_word[rde_pkg::BASE_W-1:0] = 5'd10;
      write_reg(rde_pkg::REG_BASE, base_word);
      write_reg(rde_pkg::REG_CHARS_LOW, ($urandom_range(1) != 0) ? {$urandom, $urandom}
                                                : rde_pkg::CHARS_LOW_RESET);
      write_reg(rde_pkg::REG_CHARS_HIGH, ($urandom_range(1) != 0) ? {$urandom, $urandom}
                                                 : rde_pkg::CHARS_HIGH_RESET);
      if ($urandom_range(2) == 0)
        write_reg(REG_UNUSED, {$urandom, $urandom});
      // One phase runs both sides with no idle cycles at all.
      idle_on = (ph != 3);
      for (int n = 0; n < 17; n++)
        send_number(random_number(), 0, '0);
    end

    wait_drained();
    repeat (4300) @(posedge clk);
    err_count += expected_digits.size();
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
